[rtl/assert_macros.svh]
// Assertion macros used by the engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/c32we_pkg.sv]
// Shared types, constants and bit functions for the word-wise CRC-32 engine.
package c32we_pkg;

    localparam int CRC_W     = 32;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W    = 8;

    localparam logic [CRC_W-1:0] INIT_RESET = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_VALUE,
        REG_CRC_POLYNOMIAL,
        REG_IN_BYTE_REVERSE,
        REG_OUT_REVERSE
    } cfg_reg_t;

    typedef enum logic [CNT_W-1:0] {
        CNT_NONE = 3'd0,
        CNT_ONE  = 3'd1,
        CNT_TWO  = 3'd2,
        CNT_THREE = 3'd3
    } byte_cnt_t;

    // Column i holds the 32-shift image of bit i of the CRC word.
    typedef logic [CRC_W-1:0][CRC_W-1:0] col_table_t;

    typedef struct packed {
        logic [CRC_W-1:0] init_value;
        logic             in_byte_reverse;
        logic             out_reverse;
    } cfg_t;

    typedef struct packed {
        logic stage_full;
        logic out_full;
    } core_status_t;

    function automatic logic [CRC_W-1:0] reverse_bits(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++)
        begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] flip_each_byte(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int b = 0; b < CRC_W / BYTE_W; b++)
        begin
            for (int k = 0; k < BYTE_W; k++)
            begin
                r[b*BYTE_W + k] = v[b*BYTE_W + BYTE_W-1-k];
            end
        end
        return r;
    endfunction

    // One MSB-first shift of the LFSR.
    function automatic logic [CRC_W-1:0] crc_shift1(input logic [CRC_W-1:0] c,
                                                    input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] r;
        r = {c[CRC_W-2:0], 1'b0};
        if (c[CRC_W-1])
        begin
            r = r ^ poly;
        end
        return r;
    endfunction

endpackage

[rtl/c32we_cfg.sv]
// Configuration registers and the registered column table derived from the polynomial.
module c32we_cfg
    import c32we_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CRC_W-1:0]     cfg_data,
    output cfg_t                 cfg,
    output col_table_t           col_table
);

    logic [CRC_W-1:0] init_reg;
    logic [CRC_W-1:0] poly_reg;
    logic             in_rev_reg;
    logic             out_rev_reg;
    col_table_t       col_reg;
    col_table_t       col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg    <= INIT_RESET;
            poly_reg    <= POLY_RESET;
            in_rev_reg  <= 1'b0;
            out_rev_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INIT_VALUE:      init_reg    <= cfg_data;
                REG_CRC_POLYNOMIAL:  poly_reg    <= cfg_data;
                REG_IN_BYTE_REVERSE: in_rev_reg  <= cfg_data[0];
                REG_OUT_REVERSE:     out_rev_reg <= cfg_data[0];
                default:             init_reg    <= init_reg;
            endcase
        end
    end

    // Bit i maps to x^(32+i) mod P; column 0 is the polynomial itself.
    always_comb
    begin
        col_next[0] = poly_reg;
        for (int i = 1; i < CRC_W; i++)
        begin
            col_next[i] = crc_shift1(col_next[i-1], poly_reg);
        end
    end

    // Depends on configuration only; registered from the polynomial register, so it follows a write in the next cycle.
    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
    end

    assign cfg.init_value      = init_reg;
    assign cfg.in_byte_reverse = in_rev_reg;
    assign cfg.out_reverse     = out_rev_reg;
    assign col_table           = col_reg;

endmodule

[rtl/c32we_pack.sv]
// Byte packing of an input word: big-endian full word, masked little-endian tail.
module c32we_pack
    import c32we_pkg::*;
(
    input  logic [CRC_W-1:0] data_word,
    input  logic [CNT_W-1:0] byte_count,
    input  logic             in_byte_reverse,
    output logic [CRC_W-1:0] packed_word,
    output logic             absorb
);

    logic [CRC_W-1:0] ordered;

    always_comb
    begin
        absorb = 1'b1;
        case (byte_cnt_t'(byte_count))
            CNT_NONE:
            begin
                absorb  = 1'b0;
                ordered = '0;
            end
            CNT_ONE:   ordered = {24'd0, data_word[7:0]};
            CNT_TWO:   ordered = {16'd0, data_word[15:0]};
            CNT_THREE: ordered = {8'd0, data_word[23:0]};
            // four and above: full word, first byte to the top
            default:   ordered = {data_word[7:0], data_word[15:8],
                                  data_word[23:16], data_word[31:24]};
        endcase
        packed_word = in_byte_reverse ? flip_each_byte(ordered) : ordered;
    end

endmodule

[rtl/c32we_core.sv]
// Input stage, running CRC update through the column table, and result register.
module c32we_core
    import c32we_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CRC_W-1:0] packed_word,
    input  logic             absorb,
    input  logic             first_word,
    input  cfg_t             cfg,
    input  col_table_t       col_table,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CRC_W-1:0] crc_value,
    output core_status_t     status
);

    logic             stage_full_reg;
    logic             stage_full_next;
    logic [CRC_W-1:0] stage_packed_reg;
    logic             stage_absorb_reg;
    logic             stage_first_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CRC_W-1:0] crc_out_reg;
    logic [CRC_W-1:0] crc_out_next;
    logic [CRC_W-1:0] running_crc_reg;
    logic [CRC_W-1:0] running_crc_next;

    logic             load_out;
    logic             accept;
    logic [CRC_W-1:0] base_crc;
    logic [CRC_W-1:0] mixed;
    logic [CRC_W-1:0] shifted;
    logic [CRC_W-1:0] crc_new;

    assign load_out = stage_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_full_reg && !load_out;
    assign accept   = in_valid && !in_stall;

    assign stage_full_next  = accept || (stage_full_reg && !load_out);
    assign out_valid_next   = load_out || (out_valid_reg && out_stall);

    assign base_crc = stage_first_reg ? cfg.init_value : running_crc_reg;
    assign mixed    = base_crc ^ stage_packed_reg;

    // 32 shifts collapse to an XOR of the columns picked by the set bits
    always_comb
    begin
        shifted = '0;
        for (int i = 0; i < CRC_W; i++)
        begin
            if (mixed[i])
            begin
                shifted = shifted ^ col_table[i];
            end
        end
    end

    assign crc_new          = stage_absorb_reg ? shifted : base_crc;
    assign running_crc_next = load_out ? crc_new : running_crc_reg;
    assign crc_out_next     = cfg.out_reverse ? reverse_bits(crc_new) : crc_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_full_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            running_crc_reg <= '0;
        end
        else
        begin
            stage_full_reg  <= stage_full_next;
            out_valid_reg   <= out_valid_next;
            running_crc_reg <= running_crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_packed_reg <= packed_word;
            stage_absorb_reg <= absorb;
            stage_first_reg  <= first_word;
        end
        if (load_out)
        begin
            crc_out_reg <= crc_out_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign crc_value         = crc_out_reg;
    assign status.stage_full = stage_full_reg;
    assign status.out_full   = out_valid_reg;

endmodule

[rtl/crc32_word_engine_top.sv]
// Top level of the word-wise CRC-32 engine with configurable polynomial.
// A word passes the input stage, then the result register. Throughput: one word per cycle
// while the result is not stalled; the running CRC is one XOR of table columns per word.
// The column table is registered from the polynomial register; the input stage covers that delay.
// Reset: asynchronous, active low; clears both stages and the running CRC, loads defaults.
`include "assert_macros.svh"

module crc32_word_engine_top
    import c32we_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CRC_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CRC_W-1:0]     data_word,
    input  logic [CNT_W-1:0]     byte_count,
    input  logic                 first_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CRC_W-1:0]     crc_value
);

    cfg_t             cfg;
    col_table_t       col_table;
    logic [CRC_W-1:0] packed_word;
    logic             absorb;
    core_status_t     status;

    c32we_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .col_table (col_table)
    );

    c32we_pack u_pack (
        .data_word       (data_word),
        .byte_count      (byte_count),
        .in_byte_reverse (cfg.in_byte_reverse),
        .packed_word     (packed_word),
        .absorb          (absorb)
    );

    c32we_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .packed_word (packed_word),
        .absorb      (absorb),
        .first_word  (first_word),
        .cfg         (cfg),
        .col_table   (col_table),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .crc_value   (crc_value),
        .status      (status)
    );

    // Input holds off only while both stages are full and the result is blocked.
    `CHK_SAME(a_stall_cause, in_stall, status.stage_full && out_valid && out_stall, "input stall without blocked output")
    // A transfer always lands in the input stage.
    `CHK_NEXT(a_stage_fill, in_valid && !in_stall, status.stage_full, "accepted word lost")
    // Result taken with nothing staged behind it: drop valid.
    `CHK_NEXT(a_out_drain, out_valid && !out_stall && !status.stage_full, !out_valid, "result repeated")

endmodule
